@@ design/bcad_pkg.sv @@
// ----------------------------------------------------------------------------
// bcad_pkg
// shared types and constants for the banked cpu bus address decoder
// ----------------------------------------------------------------------------
package bcad_pkg;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_DIV,
    ST_PUSH
  } state_e;

  // read target classes
  typedef enum logic [2:0] {
    RD_LOW,
    RD_WRAM,
    RD_BANK,
    RD_FIXED,
    RD_CARD,
    RD_BIOS,
    RD_BRAM
  } rd_kind_e;

  // write target classes
  typedef enum logic [2:0] {
    WR_NONE,
    WR_WRAM,
    WR_BRAM,
    WR_CARD,
    WR_VEC_SET,
    WR_VEC_CLR,
    WR_BANK
  } wr_kind_e;

  typedef struct packed {
    rd_kind_e    rd;
    wr_kind_e    wr;
    logic [7:0]  fixed;
    logic [23:0] rom_off;
    logic [23:0] bank_next;
  } dec_t;

  // rom source codes
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_PROG = 2'd1;
  localparam logic [1:0] SRC_BIOS = 2'd2;

  localparam logic [23:0] ROM_SIZE_RST  = 24'h100000;
  localparam logic [23:0] BANK_STEP     = 24'h100000;
  localparam logic [23:0] VECTOR_BYTES  = 24'd128;

  localparam logic [11:0] PG_300 = 12'h300;
  localparam logic [11:0] PG_320 = 12'h320;
  localparam logic [11:0] PG_340 = 12'h340;
  localparam logic [11:0] PG_380 = 12'h380;
  localparam logic [11:0] PG_3A0 = 12'h3a0;
  localparam logic [11:0] PG_3C0 = 12'h3c0;
  localparam logic [11:0] PG_800 = 12'h800;
  localparam logic [7:0]  SEG_C0 = 8'hc0;
  localparam logic [7:0]  SEG_D0 = 8'hd0;
  localparam logic [10:0] BLK_400 = 11'h200;   // 0x400000 >> 13
  localparam logic [19:0] BANK_REG_BLK = 20'h2ffff;
  localparam logic [7:0]  VEC_SET_LOW = 8'h03;
  localparam logic [7:0]  VEC_CLR_LOW = 8'h13;

  localparam logic [7:0] BYTE_FF = 8'hff;
  localparam logic [7:0] BYTE_F0 = 8'hf0;
  localparam logic [7:0] BYTE_00 = 8'h00;

  // low window remainder
  localparam int unsigned  DIV_STEPS = 20;
  localparam logic [4:0]   DIV_LAST  = 5'(DIV_STEPS - 1);

endpackage

@@ design/bcad_ram.sv @@
// ----------------------------------------------------------------------------
// bcad_ram
// single port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module bcad_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bcad_modu.sv @@
// ----------------------------------------------------------------------------
// bcad_modu
// bit-serial remainder of a 20-bit address by the rom size
// ----------------------------------------------------------------------------
module bcad_modu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        done_o,
  output logic [23:0] rem_o
);
  import bcad_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [19:0] dvd_q, dvd_d;
  logic [23:0] dvs_q, dvs_d;
  logic [23:0] rem_q, rem_d;
  logic [24:0] shifted;
  logic [24:0] diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[19]};
    diff    = shifted - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // restoring step: one quotient bit per cycle
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[23:0];
      end else begin
        rem_d = shifted[23:0];
      end
      dvd_d = {dvd_q[18:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ design/bcad_dec.sv @@
// ----------------------------------------------------------------------------
// bcad_dec
// address map decode for reads and writes, bank limit checks
// ----------------------------------------------------------------------------
module bcad_dec (
  input  logic [23:0]   addr_i,
  input  logic [7:0]    wdata_i,
  input  logic [23:0]   size_i,
  input  logic [23:0]   bank_base_i,
  output bcad_pkg::dec_t dec_o
);
  import bcad_pkg::*;

  logic [11:0] page;
  logic [7:0]  seg;
  logic [23:0] bank_off;
  logic        big_rom;
  logic        bank_ok;
  logic [3:0]  bank_sel;
  logic [23:0] bank_new;

  always_comb begin
    page     = addr_i[23:12];
    seg      = addr_i[23:16];
    bank_off = bank_base_i + {4'd0, addr_i[19:0]};
    big_rom  = size_i > BANK_STEP;
    bank_ok  = (addr_i[23:20] == 4'h2) && big_rom && (bank_off < size_i);
    bank_sel = {1'b0, wdata_i[2:0]} + 4'd1;
    bank_new = {bank_sel, 20'd0};

    dec_o           = '0;
    dec_o.rd        = RD_FIXED;
    dec_o.wr        = WR_NONE;
    dec_o.fixed     = BYTE_F0;
    dec_o.bank_next = (bank_new >= size_i) ? BANK_STEP : bank_new;

    // read map, first match wins
    if (addr_i[23:20] == 4'h0) begin
      dec_o.rd = RD_LOW;
    end else if (addr_i[23:20] == 4'h1) begin
      dec_o.rd = RD_WRAM;
    end else if (bank_ok) begin
      dec_o.rd      = RD_BANK;
      dec_o.rom_off = bank_off;
    end else if (page == PG_300 || page == PG_320 || page == PG_340) begin
      dec_o.fixed = BYTE_FF;
    end else if (page == PG_380 || page == PG_3C0) begin
      dec_o.fixed = BYTE_00;
    end else if (page == PG_3A0) begin
      dec_o.fixed = BYTE_F0;
    end else if (addr_i[23:13] == BLK_400) begin
      dec_o.fixed = BYTE_00;
    end else if (page == PG_800) begin
      if (addr_i[0]) begin
        dec_o.fixed = BYTE_FF;
      end else begin
        dec_o.rd = RD_CARD;
      end
    end else if (seg == SEG_C0) begin
      dec_o.rd      = RD_BIOS;
      dec_o.rom_off = {7'd0, addr_i[16:0]};
    end else if (seg == SEG_D0) begin
      dec_o.rd = RD_BRAM;
    end

    // write map
    if (addr_i[23:20] == 4'h1) begin
      dec_o.wr = WR_WRAM;
    end else if (seg == SEG_D0) begin
      dec_o.wr = WR_BRAM;
    end else if (page == PG_320) begin
      dec_o.wr = WR_NONE;
    end else if (page == PG_3A0) begin
      if (addr_i[7:0] == VEC_SET_LOW) begin
        dec_o.wr = WR_VEC_SET;
      end else if (addr_i[7:0] == VEC_CLR_LOW) begin
        dec_o.wr = WR_VEC_CLR;
      end
    end else if (page == PG_800) begin
      dec_o.wr = WR_CARD;
    end else if (addr_i[23:4] == BANK_REG_BLK && big_rom) begin
      dec_o.wr = WR_BANK;
    end
  end

endmodule

@@ design/banked_cpu_bus_address_decoder.sv @@
// ----------------------------------------------------------------------------
// banked_cpu_bus_address_decoder
// byte bus decoder with work, backup and card ram, rom bank and vector overlay
// ----------------------------------------------------------------------------
// flow: accept captures a word, ST_EXEC decodes it and ST_PUSH moves the
//   result to the output register; ram and card reads add ST_RDATA, reads
//   below 0x100000 with a nonzero rom size add ST_DIV (bit-serial remainder
//   by rom size, one bit per cycle); one word in flight, next taken in ST_IDLE
// reset: after reset a clearing pass over every ram address zeroes all rams;
//   no word is taken during it, configuration writes are taken throughout
module banked_cpu_bus_address_decoder #(
  parameter int unsigned RAM_DEPTH  = 65536,
  parameter int unsigned CARD_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [23:0] address_i,
  input  logic [7:0]  write_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  rom_source_o,
  output logic [23:0] rom_address_o
);
  import bcad_pkg::*;

  localparam int unsigned RamAw  = $clog2(RAM_DEPTH);
  localparam int unsigned CardAw = $clog2(CARD_DEPTH);

  // control state
  state_e      state_q, state_d;
  logic [RamAw-1:0] clr_q, clr_d;
  logic [23:0] size_q, size_d;
  logic [23:0] bank_q, bank_d;
  logic        vec_q, vec_d;
  logic        out_valid_q, out_valid_d;

  // captured word
  logic        mode_q;
  logic [23:0] addr_q;
  logic [7:0]  wdata_q;
  logic        accept;

  // pending result and output register
  logic [7:0]  res_data_q, res_data_d;
  logic [1:0]  res_src_q, res_src_d;
  logic [23:0] res_addr_q, res_addr_d;
  logic [7:0]  rd_data_q, rd_data_d;
  logic [1:0]  rd_src_q, rd_src_d;
  logic [23:0] rd_addr_q, rd_addr_d;

  // datapath parts
  dec_t        dec;
  logic        div_start;
  logic        div_done;
  logic [23:0] div_rem;
  logic        clearing;
  logic        wram_we, bram_we, card_we;
  logic [RamAw-1:0]  ram_addr;
  logic [CardAw-1:0] card_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  wram_rdata, bram_rdata, card_rdata;
  logic [23:0] low_off;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign clearing   = (state_q == ST_CLEAR);

  bcad_dec u_dec (
    .addr_i      (addr_q),
    .wdata_i     (wdata_q),
    .size_i      (size_q),
    .bank_base_i (bank_q),
    .dec_o       (dec)
  );

  bcad_modu u_modu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (addr_q[19:0]),
    .divisor_i  (size_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // during the clearing pass all rams take zeroes at the sweep address
  assign ram_addr  = clearing ? clr_q : addr_q[RamAw-1:0];
  assign card_addr = clearing ? clr_q[CardAw-1:0] : addr_q[CardAw:1];
  assign ram_wdata = clearing ? BYTE_00 : wdata_q;

  bcad_ram #(.DEPTH(RAM_DEPTH), .WIDTH(8)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (wram_rdata)
  );

  bcad_ram #(.DEPTH(RAM_DEPTH), .WIDTH(8)) u_bram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (bram_rdata)
  );

  bcad_ram #(.DEPTH(CARD_DEPTH), .WIDTH(8)) u_card (
    .clk_i   (clk_i),
    .we_i    (card_we),
    .addr_i  (card_addr),
    .wdata_i (ram_wdata),
    .rdata_o (card_rdata)
  );

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    size_d      = cfg_we_i ? cfg_data_i : size_q;
    bank_d      = bank_q;
    vec_d       = vec_q;
    out_valid_d = out_valid_q;
    res_data_d  = res_data_q;
    res_src_d   = res_src_q;
    res_addr_d  = res_addr_q;
    rd_data_d   = rd_data_q;
    rd_src_d    = rd_src_q;
    rd_addr_d   = rd_addr_q;
    div_start   = 1'b0;
    wram_we     = clearing;
    bram_we     = clearing;
    card_we     = clearing;
    low_off     = '0;

    // output register drains independently of the sequencer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + RamAw'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_data_d = BYTE_00;
        res_src_d  = SRC_NONE;
        res_addr_d = '0;
        state_d    = ST_PUSH;
        if (mode_q) begin
          case (dec.wr)
            WR_WRAM:    wram_we = 1'b1;
            WR_BRAM:    bram_we = 1'b1;
            WR_CARD:    card_we = 1'b1;
            WR_VEC_SET: vec_d   = 1'b1;
            WR_VEC_CLR: vec_d   = 1'b0;
            WR_BANK:    bank_d  = dec.bank_next;
            default:    ;
          endcase
        end else begin
          case (dec.rd)
            RD_LOW: begin
              if (size_q == '0) begin
                // no wrap with a zero rom size
                low_off    = {4'd0, addr_q[19:0]};
                res_addr_d = low_off;
                res_src_d  = (vec_q && low_off < VECTOR_BYTES) ? SRC_BIOS : SRC_PROG;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            RD_WRAM, RD_BRAM, RD_CARD: begin
              state_d = ST_RDATA;
            end
            RD_BANK: begin
              res_src_d  = SRC_PROG;
              res_addr_d = dec.rom_off;
            end
            RD_BIOS: begin
              res_src_d  = SRC_BIOS;
              res_addr_d = dec.rom_off;
            end
            default: begin
              res_data_d = dec.fixed;
            end
          endcase
        end
      end

      ST_RDATA: begin
        case (dec.rd)
          RD_WRAM: res_data_d = wram_rdata;
          RD_BRAM: res_data_d = bram_rdata;
          default: res_data_d = card_rdata;
        endcase
        state_d = ST_PUSH;
      end

      ST_DIV: begin
        if (div_done) begin
          // vector overlay covers the first bytes of the wrapped window
          low_off    = div_rem;
          res_addr_d = low_off;
          res_src_d  = (vec_q && low_off < VECTOR_BYTES) ? SRC_BIOS : SRC_PROG;
          state_d    = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          rd_data_d   = res_data_q;
          rd_src_d    = res_src_q;
          rd_addr_d   = res_addr_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      size_q      <= ROM_SIZE_RST;
      bank_q      <= BANK_STEP;
      vec_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      size_q      <= size_d;
      bank_q      <= bank_d;
      vec_q       <= vec_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    res_data_q <= res_data_d;
    res_src_q  <= res_src_d;
    res_addr_q <= res_addr_d;
    rd_data_q  <= rd_data_d;
    rd_src_q   <= rd_src_d;
    rd_addr_q  <= rd_addr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_data_q;
  assign rom_source_o  = rd_src_q;
  assign rom_address_o = rd_addr_q;

endmodule
